@@ rtl/vec3_arithmetic_unit_top_defines.svh @@
// Assertion macros for the checker file of the vector unit.
// No dependencies.
`ifndef VEC3_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define VEC3_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define VAU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define VAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// holds on the cycle after a reset cycle
`define VAU_ASSERT_AFTER_RST(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) $past(rst) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/vau_pkg.sv @@
// Package of the vector unit: widths, opcodes, pipeline tags and step functions.
// No dependencies.
package vau_pkg;

   localparam int WORD_BITS     = 32;
   localparam int FRAC_BITS     = 16;
   localparam int LANES         = 3;
   localparam int OP_BITS       = 4;
   localparam int REQ_DATA_BITS = (2 * LANES + 1) * WORD_BITS;
   localparam int RSP_DATA_BITS = (LANES + 1) * WORD_BITS;
   localparam int DVD_BITS      = WORD_BITS + FRAC_BITS;
   localparam int RAD_BITS      = 2 * WORD_BITS;
   localparam int SQ_REM_BITS   = WORD_BITS + 4;
   localparam int DV_REM_BITS   = WORD_BITS + 1;
   localparam int ACC_BITS      = 2 * WORD_BITS + 2;
   localparam int SQRT_STAGES   = WORD_BITS / 2;
   localparam int DIV_STAGES    = DVD_BITS / 2;

   typedef logic [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type FIX_ONE  =
      {{(WORD_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD   = 4'd0,
      OP_SUB   = 4'd1,
      OP_MUL   = 4'd2,
      OP_DIV   = 4'd3,
      OP_SADD  = 4'd4,
      OP_SSUB  = 4'd5,
      OP_SMUL  = 4'd6,
      OP_SDIV  = 4'd7,
      OP_NORM2 = 4'd8,
      OP_NORM  = 4'd9,
      OP_UNIT  = 4'd10,
      OP_DOT   = 4'd11,
      OP_CROSS = 4'd12,
      OP_LERP  = 4'd13
   } op_type;

   // sideband after the divider inputs are known
   typedef struct packed {
      logic                    vld;
      op_type                  op;
      logic [LANES-1:0]        neg;
      logic [LANES-1:0]        dzl;
      word_type [LANES-1:0]    r;
      word_type                sr;
      logic                    ovf;
      logic                    dz;
   } post_tag_type;

   // sideband ahead of the divider
   typedef struct packed {
      post_tag_type                     base;
      logic [LANES-1:0][DVD_BITS-1:0]   dvd;
      word_type [LANES-1:0]             dvs;
   } pre_tag_type;

   typedef struct packed {
      logic [RAD_BITS-1:0]    rad;
      logic [SQ_REM_BITS-1:0] rem;
      word_type               root;
   } sq_state_type;

   typedef struct packed {
      logic [DVD_BITS-1:0]    num;
      logic [DV_REM_BITS-1:0] rem;
      word_type               dvs;
   } dv_state_type;

   function automatic word_type mag_of(input word_type x);
      return x[WORD_BITS-1] ? word_type'(~x + 1'b1) : x;
   endfunction

   // shift right by FRAC_BITS toward zero, then saturate; returns {ovf, value}
   function automatic logic [WORD_BITS:0] trunc_sat(input logic signed [ACC_BITS-1:0] x);
      logic signed [ACC_BITS-1:0] adj;
      logic signed [ACC_BITS-1:0] sh;
      adj = x + (x[ACC_BITS-1] ? ACC_BITS'((1 << FRAC_BITS) - 1) : ACC_BITS'(0));
      sh  = adj >>> FRAC_BITS;
      if ((&sh[ACC_BITS-1:WORD_BITS-1]) || !(|sh[ACC_BITS-1:WORD_BITS-1]))
         return {1'b0, sh[WORD_BITS-1:0]};
      return {1'b1, sh[ACC_BITS-1] ? WORD_MIN : WORD_MAX};
   endfunction

   // one root bit of the digit-by-digit square root
   function automatic sq_state_type sq_step(input sq_state_type s);
      sq_state_type           n;
      logic [SQ_REM_BITS-1:0] rem2;
      logic [SQ_REM_BITS-1:0] trial;
      rem2  = {s.rem[SQ_REM_BITS-3:0], s.rad[RAD_BITS-1 -: 2]};
      trial = SQ_REM_BITS'({s.root, 2'b01});
      n.rad = s.rad << 2;
      if (rem2 >= trial) begin
         n.rem  = rem2 - trial;
         n.root = {s.root[WORD_BITS-2:0], 1'b1};
      end else begin
         n.rem  = rem2;
         n.root = {s.root[WORD_BITS-2:0], 1'b0};
      end
      return n;
   endfunction

   // one quotient bit of restoring division
   function automatic dv_state_type dv_step(input dv_state_type s);
      dv_state_type           n;
      logic [DV_REM_BITS-1:0] rem2;
      rem2  = {s.rem[DV_REM_BITS-2:0], s.num[DVD_BITS-1]};
      n.dvs = s.dvs;
      if (rem2 >= DV_REM_BITS'(s.dvs)) begin
         n.rem = rem2 - DV_REM_BITS'(s.dvs);
         n.num = {s.num[DVD_BITS-2:0], 1'b1};
      end else begin
         n.rem = rem2;
         n.num = {s.num[DVD_BITS-2:0], 1'b0};
      end
      return n;
   endfunction

endpackage

@@ rtl/vau_sqrt.sv @@
// Pipelined integer square root, two root bits per stage.
// Depends on vau_pkg.
module vau_sqrt
   import vau_pkg::*;
(
   input  logic                clock,
   input  logic                en,
   input  logic [RAD_BITS-1:0] rad_in,
   output word_type            root_out
);

   sq_state_type st_ff [SQRT_STAGES];
   sq_state_type init;

   always_comb begin
      init      = '0;
      init.rad  = rad_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff[0] <= sq_step(sq_step(init));
         for (int j = 1; j < SQRT_STAGES; j++) begin
            st_ff[j] <= sq_step(sq_step(st_ff[j-1]));
         end
      end
   end

   assign root_out = st_ff[SQRT_STAGES-1].root;

endmodule

@@ rtl/vau_div.sv @@
// Pipelined unsigned divider, one lane per vector component, two bits per stage.
// Depends on vau_pkg.
module vau_div
   import vau_pkg::*;
(
   input  logic                            clock,
   input  logic                            en,
   input  logic [LANES-1:0][DVD_BITS-1:0]  dvd_in,
   input  word_type [LANES-1:0]            dvs_in,
   output logic [LANES-1:0][DVD_BITS-1:0]  quo_out
);

   dv_state_type st_ff [DIV_STAGES][LANES];
   dv_state_type init [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         init[k]     = '0;
         init[k].num = dvd_in[k];
         init[k].dvs = dvs_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < LANES; k++) begin
            st_ff[0][k] <= dv_step(dv_step(init[k]));
            for (int j = 1; j < DIV_STAGES; j++) begin
               st_ff[j][k] <= dv_step(dv_step(st_ff[j-1][k]));
            end
         end
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         quo_out[k] = st_ff[DIV_STAGES-1][k].num;
      end
   end

endmodule

@@ rtl/vec3_arithmetic_unit_top.sv @@
// Every opcode takes the same path from item acceptance to rsp_tvalid.
// Throughput: one item per cycle unless the output stalls; the 16-stage square root
// and 24-stage divider are fully pipelined, so every opcode streams at full rate.
// Reset (synchronous, active high) clears all valid bits; payload is not reset.
// Top level of the three-component Q16.16 vector unit.
// Depends on vau_pkg, vau_sqrt, vau_div.
module vec3_arithmetic_unit_top
   import vau_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // ux, uy, uz, vx, vy, vz, scalar (lowest bits first)
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // opcode
   input  logic [OP_BITS-1:0]       req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // rx, ry, rz, scalar_result (lowest bits first)
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // overflow, divide_by_zero (lowest bit first)
   output logic [1:0]               rsp_tuser
);

   // Whole pipeline moves together; it only freezes when the output item is
   // held by the consumer.
   logic adv;

   // stage 0: input register
   logic                        s0_vld_ff;
   op_type                      s0_op_ff;
   logic signed [WORD_BITS-1:0] s0_u_ff [LANES];
   logic signed [WORD_BITS-1:0] s0_v_ff [LANES];
   logic signed [WORD_BITS-1:0] s0_s_ff;

   // stage 1: multiplier operands, add/sub and divider setup
   pre_tag_type                 s1_tag_in, s1_tag_ff;
   logic signed [WORD_BITS-1:0] ma_in [LANES], mb_in [LANES], mc_in [LANES], md_in [LANES];
   logic signed [WORD_BITS-1:0] s1_ma_ff [LANES], s1_mb_ff [LANES];
   logic signed [WORD_BITS-1:0] s1_mc_ff [LANES], s1_md_ff [LANES];

   // stage 2: products
   pre_tag_type                   s2_tag_ff;
   logic signed [RAD_BITS-1:0]    s2_pa_ff [LANES], s2_pb_ff [LANES];

   // stage 3: sums
   pre_tag_type                   s3_tag_ff;
   logic signed [ACC_BITS-1:0]    s3_comb_ff [LANES];
   logic signed [ACC_BITS-1:0]    s3_tot_ff;

   // stage 4: round and saturate
   pre_tag_type                   s4_tag_in, s4_tag_ff;
   logic [RAD_BITS-1:0]           s4_rad_ff;

   // square root and divider sections
   pre_tag_type                   sq_tag_ff [SQRT_STAGES];
   word_type                      root;
   post_tag_type                  dv_tag_in;
   logic [LANES-1:0][DVD_BITS-1:0] dv_dvd_in;
   word_type [LANES-1:0]          dv_dvs_in;
   post_tag_type                  dv_tag_ff [DIV_STAGES];
   logic [LANES-1:0][DVD_BITS-1:0] quo;

   // output
   post_tag_type                  fin;
   logic                          rsp_tvalid_ff;
   logic [RSP_DATA_BITS-1:0]      rsp_tdata_ff, rsp_tdata_in;
   logic [1:0]                    rsp_tuser_ff, rsp_tuser_in;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 0 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_tvalid;
         s0_op_ff  <= op_type'(req_tuser);
         for (int k = 0; k < LANES; k++) begin
            s0_u_ff[k] <= req_tdata[k*WORD_BITS +: WORD_BITS];
            s0_v_ff[k] <= req_tdata[(LANES+k)*WORD_BITS +: WORD_BITS];
         end
         s0_s_ff <= req_tdata[2*LANES*WORD_BITS +: WORD_BITS];
      end
   end

   // ---------------- stage 1 ----------------
   always_comb begin
      logic signed [WORD_BITS-1:0] t, omt, b;
      logic signed [WORD_BITS:0]   sum;
      s1_tag_in          = '0;
      s1_tag_in.base.vld = s0_vld_ff;
      s1_tag_in.base.op  = s0_op_ff;
      b                  = '0;
      sum                = '0;
      // lerp parameter clamped to [0, 1.0]
      if (s0_s_ff < 0)
         t = '0;
      else if (s0_s_ff > $signed(FIX_ONE))
         t = FIX_ONE;
      else
         t = s0_s_ff;
      omt = FIX_ONE - t;
      for (int k = 0; k < LANES; k++) begin
         ma_in[k] = '0;
         mb_in[k] = '0;
         mc_in[k] = '0;
         md_in[k] = '0;
      end
      case (s0_op_ff)
         OP_ADD, OP_SUB, OP_SADD, OP_SSUB: begin
            for (int k = 0; k < LANES; k++) begin
               b = (s0_op_ff == OP_ADD || s0_op_ff == OP_SUB) ? s0_v_ff[k] : s0_s_ff;
               if (s0_op_ff == OP_SUB || s0_op_ff == OP_SSUB)
                  sum = (WORD_BITS+1)'(s0_u_ff[k]) - (WORD_BITS+1)'(b);
               else
                  sum = (WORD_BITS+1)'(s0_u_ff[k]) + (WORD_BITS+1)'(b);
               if (sum[WORD_BITS] != sum[WORD_BITS-1]) begin
                  s1_tag_in.base.r[k] = sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
                  s1_tag_in.base.ovf  = 1'b1;
               end else begin
                  s1_tag_in.base.r[k] = sum[WORD_BITS-1:0];
               end
            end
         end
         OP_MUL, OP_DOT: begin
            for (int k = 0; k < LANES; k++) begin
               ma_in[k] = s0_u_ff[k];
               mb_in[k] = s0_v_ff[k];
            end
         end
         OP_SMUL: begin
            for (int k = 0; k < LANES; k++) begin
               ma_in[k] = s0_u_ff[k];
               mb_in[k] = s0_s_ff;
            end
         end
         OP_DIV, OP_SDIV: begin
            for (int k = 0; k < LANES; k++) begin
               b = (s0_op_ff == OP_DIV) ? s0_v_ff[k] : s0_s_ff;
               s1_tag_in.base.neg[k] = s0_u_ff[k][WORD_BITS-1] ^ b[WORD_BITS-1];
               s1_tag_in.dvd[k]      = {mag_of(s0_u_ff[k]), {FRAC_BITS{1'b0}}};
               s1_tag_in.dvs[k]      = mag_of(b);
               // zero divisor: saturate with the dividend's sign
               if (b == '0) begin
                  s1_tag_in.base.dzl[k] = 1'b1;
                  s1_tag_in.base.dz     = 1'b1;
                  if (s0_u_ff[k] > 0)
                     s1_tag_in.base.r[k] = WORD_MAX;
                  else if (s0_u_ff[k] < 0)
                     s1_tag_in.base.r[k] = WORD_MIN;
               end
            end
         end
         OP_NORM2, OP_NORM, OP_UNIT: begin
            for (int k = 0; k < LANES; k++) begin
               ma_in[k]              = s0_u_ff[k];
               mb_in[k]              = s0_u_ff[k];
               s1_tag_in.base.neg[k] = s0_u_ff[k][WORD_BITS-1];
               s1_tag_in.dvd[k]      = {mag_of(s0_u_ff[k]), {FRAC_BITS{1'b0}}};
            end
         end
         OP_CROSS: begin
            ma_in[0] = s0_u_ff[1]; mb_in[0] = s0_v_ff[2];
            mc_in[0] = s0_u_ff[2]; md_in[0] = s0_v_ff[1];
            ma_in[1] = s0_u_ff[2]; mb_in[1] = s0_v_ff[0];
            mc_in[1] = s0_u_ff[0]; md_in[1] = s0_v_ff[2];
            ma_in[2] = s0_u_ff[0]; mb_in[2] = s0_v_ff[1];
            mc_in[2] = s0_u_ff[1]; md_in[2] = s0_v_ff[0];
         end
         OP_LERP: begin
            for (int k = 0; k < LANES; k++) begin
               ma_in[k] = s0_u_ff[k];
               mb_in[k] = omt;
               mc_in[k] = s0_v_ff[k];
               md_in[k] = t;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_tag_ff.base.vld <= 1'b0;
      end else if (adv) begin
         s1_tag_ff <= s1_tag_in;
         for (int k = 0; k < LANES; k++) begin
            s1_ma_ff[k] <= ma_in[k];
            s1_mb_ff[k] <= mb_in[k];
            s1_mc_ff[k] <= mc_in[k];
            s1_md_ff[k] <= md_in[k];
         end
      end
   end

   // ---------------- stage 2: six 32x32 multipliers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_tag_ff.base.vld <= 1'b0;
      end else if (adv) begin
         s2_tag_ff <= s1_tag_ff;
         for (int k = 0; k < LANES; k++) begin
            s2_pa_ff[k] <= s1_ma_ff[k] * s1_mb_ff[k];
            s2_pb_ff[k] <= s1_mc_ff[k] * s1_md_ff[k];
         end
      end
   end

   // ---------------- stage 3: exact sums ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_tag_ff.base.vld <= 1'b0;
      end else if (adv) begin
         s3_tag_ff <= s2_tag_ff;
         for (int k = 0; k < LANES; k++) begin
            if (s2_tag_ff.base.op == OP_CROSS)
               s3_comb_ff[k] <= ACC_BITS'(s2_pa_ff[k]) - ACC_BITS'(s2_pb_ff[k]);
            else
               s3_comb_ff[k] <= ACC_BITS'(s2_pa_ff[k]) + ACC_BITS'(s2_pb_ff[k]);
         end
         s3_tot_ff <= ACC_BITS'(s2_pa_ff[0]) + ACC_BITS'(s2_pa_ff[1])
                    + ACC_BITS'(s2_pa_ff[2]);
      end
   end

   // ---------------- stage 4: shift toward zero, saturate ----------------
   always_comb begin
      logic [WORD_BITS:0] ts;
      s4_tag_in = s3_tag_ff;
      ts        = '0;
      case (s3_tag_ff.base.op)
         OP_MUL, OP_SMUL, OP_CROSS, OP_LERP: begin
            for (int k = 0; k < LANES; k++) begin
               ts                  = trunc_sat(s3_comb_ff[k]);
               s4_tag_in.base.r[k] = ts[WORD_BITS-1:0];
               if (ts[WORD_BITS])
                  s4_tag_in.base.ovf = 1'b1;
            end
         end
         OP_NORM2, OP_DOT: begin
            ts                = trunc_sat(s3_tot_ff);
            s4_tag_in.base.sr = ts[WORD_BITS-1:0];
            if (ts[WORD_BITS])
               s4_tag_in.base.ovf = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_tag_ff.base.vld <= 1'b0;
      end else if (adv) begin
         s4_tag_ff <= s4_tag_in;
         // sum of squares is never negative and fits the radicand
         s4_rad_ff <= s3_tot_ff[RAD_BITS-1:0];
      end
   end

   // ---------------- square root section ----------------
   vau_sqrt u_sqrt (
      .clock    (clock),
      .en       (adv),
      .rad_in   (s4_rad_ff),
      .root_out (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SQRT_STAGES; j++) begin
            sq_tag_ff[j].base.vld <= 1'b0;
         end
      end else if (adv) begin
         sq_tag_ff[0] <= s4_tag_ff;
         for (int j = 1; j < SQRT_STAGES; j++) begin
            sq_tag_ff[j] <= sq_tag_ff[j-1];
         end
      end
   end

   // divider inputs: unit divides by the root, norm takes it as its result
   always_comb begin
      dv_tag_in = sq_tag_ff[SQRT_STAGES-1].base;
      dv_dvd_in = sq_tag_ff[SQRT_STAGES-1].dvd;
      dv_dvs_in = sq_tag_ff[SQRT_STAGES-1].dvs;
      case (dv_tag_in.op)
         OP_NORM: begin
            if (root[WORD_BITS-1]) begin
               dv_tag_in.sr  = WORD_MAX;
               dv_tag_in.ovf = 1'b1;
            end else begin
               dv_tag_in.sr = root;
            end
         end
         OP_UNIT: begin
            for (int k = 0; k < LANES; k++) begin
               dv_dvs_in[k] = root;
            end
            // zero length: vector stays zero
            if (root == '0) begin
               dv_tag_in.dzl = '1;
               dv_tag_in.dz  = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------- divider section ----------------
   vau_div u_div (
      .clock   (clock),
      .en      (adv),
      .dvd_in  (dv_dvd_in),
      .dvs_in  (dv_dvs_in),
      .quo_out (quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_STAGES; j++) begin
            dv_tag_ff[j].vld <= 1'b0;
         end
      end else if (adv) begin
         dv_tag_ff[0] <= dv_tag_in;
         for (int j = 1; j < DIV_STAGES; j++) begin
            dv_tag_ff[j] <= dv_tag_ff[j-1];
         end
      end
   end

   // ---------------- quotient sign and saturation ----------------
   always_comb begin
      logic [DVD_BITS-1:0] q;
      fin = dv_tag_ff[DIV_STAGES-1];
      for (int k = 0; k < LANES; k++) begin
         q = quo[k];
         if ((fin.op == OP_DIV || fin.op == OP_SDIV || fin.op == OP_UNIT) && !fin.dzl[k]) begin
            if (fin.neg[k]) begin
               if (q > DVD_BITS'(WORD_MIN)) begin
                  fin.r[k] = WORD_MIN;
                  fin.ovf  = 1'b1;
               end else begin
                  fin.r[k] = word_type'(~q[WORD_BITS-1:0] + 1'b1);
               end
            end else begin
               if (q > DVD_BITS'(WORD_MAX)) begin
                  fin.r[k] = WORD_MAX;
                  fin.ovf  = 1'b1;
               end else begin
                  fin.r[k] = q[WORD_BITS-1:0];
               end
            end
         end
      end
      rsp_tdata_in = {fin.sr, fin.r[2], fin.r[1], fin.r[0]};
      rsp_tuser_in = {fin.dz, fin.ovf};
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= fin.vld;
         rsp_tdata_ff  <= rsp_tdata_in;
         rsp_tuser_ff  <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

@@ rtl/vau_checker.sv @@
// Port-level assertions for the vector unit, bound to the top level.
// Depends on vau_pkg and vec3_arithmetic_unit_top_defines.svh.
`include "vec3_arithmetic_unit_top_defines.svh"

module vau_checker
   import vau_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic [REQ_DATA_BITS-1:0] req_tdata,
   input logic [OP_BITS-1:0]       req_tuser,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [1:0]               rsp_tuser
);

   `VAU_ASSERT_AFTER_RST(a_reset_empty, clock, reset, !rsp_tvalid, "item valid after reset")

   `VAU_ASSERT_NEXT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled item changed")

   // pipeline never refuses input while the output register is empty
   `VAU_ASSERT_NOW(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "input blocked with empty output")

   // scalar and vector results never appear together
   `VAU_ASSERT_NOW(a_scalar_only, clock, reset, rsp_tvalid && rsp_tdata[RSP_DATA_BITS-1:LANES*WORD_BITS] != '0, rsp_tdata[LANES*WORD_BITS-1:0] == '0, "scalar result with nonzero vector")

endmodule

bind vec3_arithmetic_unit_top vau_checker u_vau_checker (.*);

@@ bench/vec3_arithmetic_unit_top_tb.sv @@
// Self-checking bench for the Q16.16 three-component vector unit: directed and random
// operations, exact wide-arithmetic prediction, random idling on both stream sides.
// Depends on vau_pkg and vec3_arithmetic_unit_top.
module vec3_arithmetic_unit_top_tb;
   import vau_pkg::*;

   typedef struct {
      logic [OP_BITS-1:0] opcode;
      word_type           u [3];
      word_type           v [3];
      word_type           s;
   } vec_op_type;

   typedef struct {
      word_type r [3];
      word_type sr;
      logic     ovf;
      logic     dz;
   } vec_res_type;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam int     WATCHDOG_CYCLES = 20000;
   localparam int     DRAIN_CYCLES = 60;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // ux, uy, uz, vx, vy, vz, scalar
   logic [OP_BITS-1:0]       req_tuser;   // opcode
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // rx, ry, rz, scalar_result
   logic [1:0]               rsp_tuser;   // overflow, divide_by_zero

   vec_op_type  pending_ops [$];
   vec_res_type expected_results [$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          fail_count;
   int          idle_cycles;

   vec3_arithmetic_unit_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor. 160-bit signed intermediates hold every exact product sum.
   // ---------------------------------------------------------------------------
   typedef logic signed [159:0] wide_type;

   // clamp to the word range, flag on overflow
   function automatic word_type clamp_word(input wide_type x, inout logic ovf);
      if (x > wide_type'(SAT_HI)) begin
         ovf = 1'b1;
         return WORD_MAX;
      end
      if (x < wide_type'(SAT_LO)) begin
         ovf = 1'b1;
         return WORD_MIN;
      end
      return word_type'(x);
   endfunction

   // drop FRAC_BITS fraction bits, rounding toward zero
   function automatic wide_type drop_frac(input wide_type x);
      if (x < 0)
         return -((-x) >>> FRAC_BITS);
      return x >>> FRAC_BITS;
   endfunction

   function automatic wide_type sx(input word_type w);
      return wide_type'(signed'(w));
   endfunction

   // fixed-point quotient with the zero-divisor rules
   function automatic word_type fix_quot(input word_type a, input word_type b,
                                         inout logic ovf, inout logic dz);
      wide_type na;
      wide_type nb;
      wide_type q;
      if (b == '0) begin
         dz = 1'b1;
         if (signed'(a) > 0)
            return WORD_MAX;
         if (signed'(a) < 0)
            return WORD_MIN;
         return '0;
      end
      na = sx(a);
      nb = sx(b);
      q  = ((na < 0 ? -na : na) <<< FRAC_BITS) / (nb < 0 ? -nb : nb);
      if ((na < 0) != (nb < 0))
         q = -q;
      return clamp_word(q, ovf);
   endfunction

   // floor square root of a nonnegative value below 2^128
   function automatic wide_type floor_root(input wide_type n);
      wide_type root;
      wide_type trial;
      root = 0;
      for (int b = 63; b >= 0; b--) begin
         trial = root | (wide_type'(1) <<< b);
         if (trial * trial <= n)
            root = trial;
      end
      return root;
   endfunction

   function automatic vec_res_type predict_vec_op(input vec_op_type op);
      vec_res_type res;
      wide_type    acc;
      wide_type    len;
      wide_type    t;
      wide_type    one;
      wide_type    q;
      logic        ovf;
      logic        dz;
      ovf = 1'b0;
      dz  = 1'b0;
      one = wide_type'(1) <<< FRAC_BITS;
      res.sr = '0;
      for (int i = 0; i < 3; i++)
         res.r[i] = '0;
      case (op.opcode)
         OP_ADD:
            for (int i = 0; i < 3; i++)
               res.r[i] = clamp_word(sx(op.u[i]) + sx(op.v[i]), ovf);
         OP_SUB:
            for (int i = 0; i < 3; i++)
               res.r[i] = clamp_word(sx(op.u[i]) - sx(op.v[i]), ovf);
         OP_MUL:
            for (int i = 0; i < 3; i++)
               res.r[i] = clamp_word(drop_frac(sx(op.u[i]) * sx(op.v[i])), ovf);
         OP_DIV:
            for (int i = 0; i < 3; i++)
               res.r[i] = fix_quot(op.u[i], op.v[i], ovf, dz);
         OP_SADD:
            for (int i = 0; i < 3; i++)
               res.r[i] = clamp_word(sx(op.u[i]) + sx(op.s), ovf);
         OP_SSUB:
            for (int i = 0; i < 3; i++)
               res.r[i] = clamp_word(sx(op.u[i]) - sx(op.s), ovf);
         OP_SMUL:
            for (int i = 0; i < 3; i++)
               res.r[i] = clamp_word(drop_frac(sx(op.u[i]) * sx(op.s)), ovf);
         OP_SDIV:
            for (int i = 0; i < 3; i++)
               res.r[i] = fix_quot(op.u[i], op.s, ovf, dz);
         OP_NORM2, OP_NORM, OP_UNIT: begin
            acc = 0;
            for (int i = 0; i < 3; i++)
               acc += sx(op.u[i]) * sx(op.u[i]);
            if (op.opcode == OP_NORM2)
               res.sr = clamp_word(drop_frac(acc), ovf);
            else begin
               len = floor_root(acc);
               if (op.opcode == OP_NORM)
                  res.sr = clamp_word(len, ovf);
               else if (len == 0)
                  dz = 1'b1;
               else begin
                  // divide by the unclamped length
                  for (int i = 0; i < 3; i++) begin
                     q = ((sx(op.u[i]) < 0 ? -sx(op.u[i]) : sx(op.u[i])) <<< FRAC_BITS)
                         / len;
                     res.r[i] = clamp_word(sx(op.u[i]) < 0 ? -q : q, ovf);
                  end
               end
            end
         end
         OP_DOT: begin
            acc = 0;
            for (int i = 0; i < 3; i++)
               acc += sx(op.u[i]) * sx(op.v[i]);
            res.sr = clamp_word(drop_frac(acc), ovf);
         end
         OP_CROSS: begin
            res.r[0] = clamp_word(drop_frac(sx(op.u[1]) * sx(op.v[2])
                                            - sx(op.u[2]) * sx(op.v[1])), ovf);
            res.r[1] = clamp_word(drop_frac(sx(op.u[2]) * sx(op.v[0])
                                            - sx(op.u[0]) * sx(op.v[2])), ovf);
            res.r[2] = clamp_word(drop_frac(sx(op.u[0]) * sx(op.v[1])
                                            - sx(op.u[1]) * sx(op.v[0])), ovf);
         end
         OP_LERP: begin
            // t clamped to [0, 1.0]
            t = sx(op.s);
            if (t < 0)
               t = 0;
            else if (t > one)
               t = one;
            for (int i = 0; i < 3; i++)
               res.r[i] = clamp_word(drop_frac(sx(op.u[i]) * (one - t)
                                               + sx(op.v[i]) * t), ovf);
         end
         default: ;  // opcodes 14 and 15 give all zeros
      endcase
      res.ovf = ovf;
      res.dz  = dz;
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic word_type rand_word();
      case ($urandom_range(9))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return '0;
         3:       return FIX_ONE;
         4:       return word_type'(signed'($urandom_range(65535)) - 32768);      // small
         5:       return word_type'(signed'($urandom_range(2097151)) - 1048576);  // +-16.0
         6:       return word_type'($urandom_range(1) ? -1 : 1);
         default: return word_type'($urandom);
      endcase
   endfunction

   function automatic vec_op_type make_vec_op(input logic [OP_BITS-1:0] opcode,
                                              input word_type uval, input word_type vval,
                                              input word_type sval);
      vec_op_type op;
      op.opcode = opcode;
      for (int i = 0; i < 3; i++) begin
         op.u[i] = uval;
         op.v[i] = vval;
      end
      op.s = sval;
      return op;
   endfunction

   function automatic vec_op_type rand_vec_op();
      vec_op_type op;
      // mostly defined opcodes, a few unused ones
      op.opcode = ($urandom_range(99) < 4) ? OP_BITS'($urandom_range(15, 14))
                                           : OP_BITS'($urandom_range(13));
      for (int i = 0; i < 3; i++) begin
         op.u[i] = rand_word();
         op.v[i] = rand_word();
      end
      op.s = rand_word();
      if (op.opcode == OP_LERP && $urandom_range(1))
         op.s = word_type'($urandom_range(65536));  // t inside [0, 1.0]
      return op;
   endfunction

   // ---------------------------------------------------------------------------
   // Driver: presents the head of pending_ops, drops it on acceptance.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(predict_vec_op(pending_ops.pop_front()));
         end
         // only sample a new idle decision when nothing is held on the bus
         if ((!req_tvalid || req_tready) ) begin
            if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser  <= pending_ops[0].opcode;
               req_tdata  <= {pending_ops[0].s, pending_ops[0].v[2], pending_ops[0].v[1],
                              pending_ops[0].v[0], pending_ops[0].u[2], pending_ops[0].u[1],
                              pending_ops[0].u[0]};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: compares each accepted result with the oldest prediction.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      vec_res_type want;
      word_type    got [4];
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            for (int i = 0; i < 4; i++)
               got[i] = rsp_tdata[i*WORD_BITS +: WORD_BITS];
            if (expected_results.size() == 0) begin
               $error("unexpected result item rsp_tdata=%h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_results.pop_front();
               for (int i = 0; i < 3; i++)
                  if (got[i] !== want.r[i]) begin
                     $error("%s: expected %h, got %h",
                            (i == 0) ? "rx" : ((i == 1) ? "ry" : "rz"),
                            want.r[i], got[i]);
                     fail_count++;
                  end
               if (got[3] !== want.sr) begin
                  $error("scalar_result: expected %h, got %h", want.sr, got[3]);
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.ovf) begin
                  $error("overflow: expected %b, got %b", want.ovf, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tuser[1] !== want.dz) begin
                  $error("divide_by_zero: expected %b, got %b", want.dz, rsp_tuser[1]);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Sequence: reset, directed items, then three phases of random items with different idling.
   // ---------------------------------------------------------------------------
   initial begin
      vec_op_type op;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      fail_count    = 0;
      idle_cycles   = 0;
      send_idle_pct = 12;
      recv_idle_pct = 59;

      // directed: every opcode, word extremes, zero divisors, zero-length unit,
      // lerp parameter below and above range, unused opcodes
      for (int k = 0; k < 14; k++)
         pending_ops.push_back(make_vec_op(OP_BITS'(k), WORD_MAX, WORD_MIN, FIX_ONE));
      pending_ops.push_back(make_vec_op(OP_DIV, WORD_MAX, '0, '0));
      pending_ops.push_back(make_vec_op(OP_SDIV, WORD_MIN, '0, '0));
      op = make_vec_op(OP_DIV, '0, '0, '0);
      op.u[0] = WORD_MAX;
      op.u[1] = WORD_MIN;
      pending_ops.push_back(op);
      pending_ops.push_back(make_vec_op(OP_UNIT, '0, '0, '0));
      pending_ops.push_back(make_vec_op(OP_UNIT, word_type'(-3), WORD_MAX, '0));
      pending_ops.push_back(make_vec_op(OP_LERP, FIX_ONE, WORD_MAX, WORD_MIN));
      pending_ops.push_back(make_vec_op(OP_LERP, WORD_MIN, WORD_MAX, WORD_MAX));
      pending_ops.push_back(make_vec_op(OP_LERP, WORD_MIN, WORD_MAX, 32'h0000_8000));
      pending_ops.push_back(make_vec_op(OP_BITS'(14), WORD_MAX, WORD_MAX, WORD_MAX));
      pending_ops.push_back(make_vec_op(OP_BITS'(15), WORD_MIN, WORD_MIN, WORD_MIN));
      pending_ops.push_back(make_vec_op(OP_NORM, WORD_MIN, WORD_MIN, '0));

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         for (int n = 0; n < 345; n++)
            pending_ops.push_back(rand_vec_op());
         wait (pending_ops.size() == 0);
         @(posedge clock);
         if (phase == 0) begin
            send_idle_pct = 59;
            recv_idle_pct = 12;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end

      wait (expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/vau_pkg.sv
rtl/vau_sqrt.sv
rtl/vau_div.sv
rtl/vec3_arithmetic_unit_top.sv
rtl/vau_checker.sv
bench/vec3_arithmetic_unit_top_tb.sv
